// ----- sv/cosine_prototype_classifier_macros.svh -----
// Assertion macros shared by the classifier RTL.
`ifndef COSINE_PROTOTYPE_CLASSIFIER_MACROS_SVH
`define COSINE_PROTOTYPE_CLASSIFIER_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CPC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define CPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- sv/cpc_pkg.sv -----
// Package with constants, types and register codes of the cosine classifier.
package cpc_pkg;
  localparam int unsigned EmbedDim      = 768;
  localparam int unsigned NumPrototypes = 4;
  localparam int unsigned ElementBits   = 16;
  localparam int unsigned AccBits       = 48;
  localparam int unsigned SimBits       = 16;
  localparam int unsigned CfgIdxBits    = 2;
  localparam int unsigned CfgDataBits   = 32;
  localparam logic [7:0] UnknownClass   = 8'd255;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_MIN_SIM   = 2'd0,
    REG_CLS_THR   = 2'd1,
    REG_CLASS_MAP = 2'd2,
    REG_UNUSED    = 2'd3
  } reg_idx_e;

  typedef enum logic {
    OP_WRITE_PROTO = 1'b0,
    OP_EMBED       = 1'b1
  } op_e;
endpackage

// ----- sv/cpc_if.sv -----
// Valid/ready channel interfaces for the input, output and configuration words.
interface cpc_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   operation;
  logic signed [cpc_pkg::ElementBits-1:0] value;
  logic [1:0]                             prototype_index;
  logic [9:0]                             dimension_index;
  logic                                   last;
  modport source (output valid, operation, value, prototype_index, dimension_index, last,
                  input ready);
  modport sink (input valid, operation, value, prototype_index, dimension_index, last,
                output ready);
endinterface

interface cpc_out_if;
  logic                               valid;
  logic                               ready;
  logic [7:0]                         label_id;
  logic signed [cpc_pkg::SimBits-1:0] confidence;
  logic [1:0]                         best_prototype;
  logic                               rejected;
  modport source (output valid, label_id, confidence, best_prototype, rejected,
                  input ready);
  modport sink (input valid, label_id, confidence, best_prototype, rejected,
                output ready);
endinterface

interface cpc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [cpc_pkg::CfgIdxBits-1:0]      index;
  logic [cpc_pkg::CfgDataBits-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/cosine_prototype_classifier.sv -----
// Order: a prototype word is stored at its accepting edge; an embedding word is read from memory, then accumulated.
// A last word then runs the square root over the energy, one division per prototype in turn,
// and a final step that registers the result.
// Throughput: one prototype word per cycle while idle; no word is taken while an embedding word is in its MAC;
// a new result waits in its last cycle while the previous one has not been taken.
// Reset clears control state, accumulators and output valid and sets configuration defaults; memory is not cleared.
module cosine_prototype_classifier #(
  parameter int unsigned EMBED_DIM      = cpc_pkg::EmbedDim,
  parameter int unsigned NUM_PROTOTYPES = cpc_pkg::NumPrototypes
) (
  input logic clk_i,
  input logic rst_ni,
  cpc_in_if.sink   in_i,
  cpc_out_if.source out_o,
  cpc_cfg_if.sink  cfg_i
);
  `include "cosine_prototype_classifier_macros.svh"

  localparam int unsigned EB   = cpc_pkg::ElementBits;
  localparam int unsigned AB   = cpc_pkg::AccBits;
  localparam int unsigned PW   = (NUM_PROTOTYPES > 1) ? $clog2(NUM_PROTOTYPES) : 1;
  localparam int unsigned DW   = (EMBED_DIM > 1) ? $clog2(EMBED_DIM) : 1;
  localparam int unsigned Words = EMBED_DIM;
  localparam logic signed [AB-1:0] AccMax = {1'b0, {(AB-1){1'b1}}};
  localparam logic signed [AB-1:0] AccMin = {1'b1, {(AB-1){1'b0}}};

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAC  = 3'd1;
  localparam logic [2:0] S_SQRT = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_q;

  // Configuration registers; the user must write them only while idle, which the block itself does not enforce.
  logic signed [15:0] min_sim_q, cls_thr_q;
  logic [31:0] class_map_q;
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_sim_q   <= 16'sd18022;
      cls_thr_q   <= '0;
      class_map_q <= 32'h03020100;
    end else if (cfg_i.valid) begin
      case (cpc_pkg::reg_idx_e'(cfg_i.index))
        cpc_pkg::REG_MIN_SIM:   min_sim_q <= cfg_i.data[15:0];
        cpc_pkg::REG_CLS_THR:   cls_thr_q <= cfg_i.data[15:0];
        cpc_pkg::REG_CLASS_MAP: class_map_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // The prototype memory holds one wide word per dimension, one lane per prototype.
  logic [NUM_PROTOTYPES*EB-1:0] proto_mem [Words];
  logic [NUM_PROTOTYPES*EB-1:0] rd_q;

  logic in_fire;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire = in_i.valid && in_i.ready;

  logic in_range;
  assign in_range = ({22'd0, in_i.dimension_index} < 32'(EMBED_DIM));
  logic proto_ok;
  assign proto_ok = ({30'd0, in_i.prototype_index} < 32'(NUM_PROTOTYPES));
  logic [DW-1:0] addr;
  assign addr = DW'(in_i.dimension_index);

  // Per-lane element write: the prototype index selects the lane.
  always_ff @(posedge clk_i) begin
    if (in_fire && in_i.operation == cpc_pkg::OP_WRITE_PROTO && in_range && proto_ok) begin
      for (int p = 0; p < NUM_PROTOTYPES; p++) begin
        if (PW'(in_i.prototype_index) == PW'(p))
          proto_mem[addr][p*EB +: EB] <= in_i.value;
      end
    end
    rd_q <= proto_mem[addr];
  end

  // Latched embedding word.
  logic signed [EB-1:0] x_q;
  logic                 use_q, last_q;

  logic signed [AB-1:0] dot_q [NUM_PROTOTYPES];
  logic [AB-1:0]        energy_q;

  // Square root: one result bit per cycle over the energy.
  logic [AB-1:0]   sq_rem_q;
  logic [AB/2-1:0] sq_root_q;
  logic [AB-1:0]   sq_x_q;
  logic [5:0]      sq_cnt_q;

  // Restoring divider: magnitude with rounding bias over the root.
  localparam int unsigned QB = AB + 1;
  logic [QB-1:0] dv_num_q, dv_quo_q;
  logic [QB-1:0] dv_rem_q;
  logic [6:0]    dv_cnt_q;
  logic [PW-1:0] dv_p_q;
  logic          dv_neg_q;
  logic signed [cpc_pkg::SimBits-1:0] best_sim_q;
  logic [PW-1:0] best_q;

  logic [7:0] o_label_q;
  logic signed [15:0] o_conf_q;
  logic [1:0] o_best_q;
  logic o_rej_q;

  // Current division operand.
  logic signed [AB-1:0] cur_dot;
  assign cur_dot = dot_q[dv_p_q];
  logic [QB-1:0] cur_mag;
  assign cur_mag = cur_dot[AB-1] ? QB'(-$signed({cur_dot[AB-1], cur_dot}))
                                 : QB'({1'b0, cur_dot});
  logic [QB-1:0] root_ext;
  assign root_ext = QB'(sq_root_q);

  // Saturated signed similarity from the quotient.
  logic signed [15:0] sim_val;
  always_comb begin
    if (root_ext == '0) sim_val = '0;
    else if (dv_neg_q) sim_val = (dv_quo_q > QB'(32768)) ? -16'sd32768
                                                         : 16'(-$signed(dv_quo_q));
    else sim_val = (dv_quo_q > QB'(32767)) ? 16'sd32767 : 16'(dv_quo_q);
  end

  logic signed [15:0] thr;
  assign thr = (cls_thr_q > min_sim_q) ? cls_thr_q : min_sim_q;

  logic [QB-1:0] rem_sh;
  assign rem_sh = {dv_rem_q[QB-2:0], dv_num_q[QB-1]};

  logic [AB+1:0] sq_trial;
  assign sq_trial = {sq_rem_q, sq_x_q[AB-1 -: 2]} -
                    {{(AB/2){1'b0}}, sq_root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      energy_q <= '0;
      for (int p = 0; p < NUM_PROTOTYPES; p++) dot_q[p] <= '0;
      out_o.valid <= 1'b0;
      use_q <= 1'b0;
      last_q <= 1'b0;
    end else begin
      if (out_o.valid && out_o.ready) out_o.valid <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_fire && in_i.operation == cpc_pkg::OP_EMBED) begin
            x_q    <= in_i.value;
            use_q  <= in_range;
            last_q <= in_i.last;
            state_q <= S_MAC;
          end
        end
        S_MAC: begin
          if (use_q) begin
            logic [AB:0] e;
            logic [EB-1:0] m;
            m = x_q[EB-1] ? EB'(-x_q) : EB'(x_q);
            e = {1'b0, energy_q} + (AB+1)'(m * m);
            energy_q <= e[AB] ? {AB{1'b1}} : e[AB-1:0];
            for (int p = 0; p < NUM_PROTOTYPES; p++) begin
              logic signed [AB:0] s;
              s = $signed({dot_q[p][AB-1], dot_q[p]}) +
                  (AB+1)'($signed(x_q) * $signed(rd_q[p*EB +: EB]));
              dot_q[p] <= (s > $signed({AccMax[AB-1], AccMax})) ? AccMax :
                          (s < $signed({AccMin[AB-1], AccMin})) ? AccMin : s[AB-1:0];
            end
          end
          if (last_q) begin
            // The energy settles at this edge, so the root loads it in the first SQRT state, not here.
            sq_rem_q  <= '0;
            sq_root_q <= '0;
            sq_cnt_q  <= 6'(AB/2 + 1);
            state_q   <= S_SQRT;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_SQRT: begin
          if (sq_cnt_q == 6'(AB/2 + 1)) begin
            sq_x_q   <= energy_q;
            sq_cnt_q <= 6'(AB/2);
          end else if (sq_cnt_q != '0) begin
            if (!sq_trial[AB+1]) begin
              sq_rem_q  <= sq_trial[AB-1:0];
              sq_root_q <= {sq_root_q[AB/2-2:0], 1'b1};
            end else begin
              sq_rem_q  <= {sq_rem_q[AB-3:0], sq_x_q[AB-1 -: 2]};
              sq_root_q <= {sq_root_q[AB/2-2:0], 1'b0};
            end
            sq_x_q   <= {sq_x_q[AB-3:0], 2'b00};
            sq_cnt_q <= sq_cnt_q - 6'd1;
          end else begin
            dv_p_q   <= '0;
            dv_cnt_q <= 7'(QB + 1);
            state_q  <= S_DIV;
          end
        end
        S_DIV: begin
          if (dv_cnt_q == 7'(QB + 1)) begin
            dv_num_q <= cur_mag + (root_ext >> 1);
            dv_neg_q <= cur_dot[AB-1];
            dv_rem_q <= '0;
            dv_quo_q <= '0;
            dv_cnt_q <= 7'(QB);
          end else if (dv_cnt_q != '0) begin
            if (rem_sh >= root_ext) begin
              dv_rem_q <= rem_sh - root_ext;
              dv_quo_q <= {dv_quo_q[QB-2:0], 1'b1};
            end else begin
              dv_rem_q <= rem_sh;
              dv_quo_q <= {dv_quo_q[QB-2:0], 1'b0};
            end
            dv_num_q <= {dv_num_q[QB-2:0], 1'b0};
            dv_cnt_q <= dv_cnt_q - 7'd1;
          end else begin
            if (dv_p_q == '0 || sim_val > best_sim_q) begin
              best_sim_q <= sim_val;
              best_q     <= dv_p_q;
            end
            if (32'(dv_p_q) == NUM_PROTOTYPES - 1) begin
              state_q <= S_OUT;
            end else begin
              dv_p_q   <= dv_p_q + PW'(1);
              dv_cnt_q <= 7'(QB + 1);
            end
          end
        end
        S_OUT: begin
          // The result register is loaded only once the previous word has been taken.
          if (!out_o.valid) begin
            o_best_q <= 2'(best_q);
            if (best_sim_q < thr) begin
              o_label_q <= cpc_pkg::UnknownClass;
              o_conf_q  <= '0;
              o_rej_q   <= 1'b1;
            end else begin
              o_label_q <= class_map_q[8*(2'(best_q)) +: 8];
              o_conf_q  <= best_sim_q;
              o_rej_q   <= 1'b0;
            end
            out_o.valid <= 1'b1;
            energy_q <= '0;
            for (int p = 0; p < NUM_PROTOTYPES; p++) dot_q[p] <= '0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.label_id       = o_label_q;
  assign out_o.confidence     = o_conf_q;
  assign out_o.best_prototype = o_best_q;
  assign out_o.rejected       = o_rej_q;

  `CPC_ASSERT_IMPL(a_rej_conf, clk_i, rst_ni, out_o.valid && out_o.rejected, out_o.confidence == 16'sd0)
  `CPC_ASSERT_IMPL(a_rej_class, clk_i, rst_ni, out_o.valid && out_o.rejected, out_o.label_id == cpc_pkg::UnknownClass)
  `CPC_ASSERT_NEXT(a_out_clear, clk_i, rst_ni, state_q == S_OUT && !out_o.valid, energy_q == '0)
  `CPC_ASSERT_IMPL(a_busy, clk_i, rst_ni, state_q != S_IDLE, !in_i.ready)
endmodule

// ----- dv/cpc_checker.sv -----
`timescale 1ns / 100ps
// Checker that predicts classifier results from the observed channels and compares them.
module cpc_checker (
  input  logic clk_i,
  input  logic rst_ni,
  cpc_in_if    in_mon,
  cpc_out_if   out_mon,
  cpc_cfg_if   cfg_mon,
  output int   fail_count_o,
  output int   pending_o
);
  localparam longint AccMax    = 64'sh7FFF_FFFF_FFFF;
  localparam longint AccMin    = -AccMax - 1;
  localparam longint EnergyMax = 64'shFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [7:0]         label_id;
    logic signed [15:0] confidence;
    logic [1:0]         best_prototype;
    logic               rejected;
  } verdict_t;

  logic signed [15:0] proto_mem [cpc_pkg::NumPrototypes][cpc_pkg::EmbedDim];
  longint             dot_acc [cpc_pkg::NumPrototypes];
  longint             energy_acc;
  logic signed [15:0] min_sim_q;
  logic signed [15:0] cls_thr_q;
  logic [31:0]        class_map_q;
  verdict_t           verdicts_due [$];

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Rounded quotient, ties away from zero, saturated to Q1.15.
  function automatic longint cosine_q15(longint dot, longint unsigned s);
    longint unsigned mag, q;
    if (s == 0) return 0;
    mag = (dot < 0) ? longint'(-dot) : longint'(dot);
    q = (mag + s / 2) / s;
    if (dot < 0) return (q > 32768) ? -32768 : -longint'(q);
    return (q > 32767) ? 32767 : longint'(q);
  endfunction

  function automatic verdict_t classify();
    verdict_t v;
    longint sims [cpc_pkg::NumPrototypes];
    longint thr;
    longint unsigned s;
    int best;
    s = floor_sqrt(energy_acc);
    for (int p = 0; p < cpc_pkg::NumPrototypes; p++) sims[p] = cosine_q15(dot_acc[p], s);
    best = 0;
    for (int p = 1; p < cpc_pkg::NumPrototypes; p++) if (sims[p] > sims[best]) best = p;
    thr = (cls_thr_q > min_sim_q) ? longint'(cls_thr_q) : longint'(min_sim_q);
    if (sims[best] < thr) begin
      v.label_id   = cpc_pkg::UnknownClass;
      v.confidence = '0;
      v.rejected   = 1'b1;
    end else begin
      v.label_id   = class_map_q[8*best +: 8];
      v.confidence = 16'(sims[best]);
      v.rejected   = 1'b0;
    end
    v.best_prototype = 2'(best);
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < cpc_pkg::NumPrototypes; p++) dot_acc[p] = 0;
      energy_acc   = 0;
      min_sim_q    = 16'sd18022;
      cls_thr_q    = '0;
      class_map_q  = 32'h0302_0100;
      fail_count_o = 0;
      verdicts_due.delete();
      pending_o    = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cpc_pkg::reg_idx_e'(cfg_mon.index))
          cpc_pkg::REG_MIN_SIM:   min_sim_q   = cfg_mon.data[15:0];
          cpc_pkg::REG_CLS_THR:   cls_thr_q   = cfg_mon.data[15:0];
          cpc_pkg::REG_CLASS_MAP: class_map_q = cfg_mon.data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (cpc_pkg::op_e'(in_mon.operation) == cpc_pkg::OP_WRITE_PROTO) begin
          if (in_mon.dimension_index < cpc_pkg::EmbedDim)
            proto_mem[in_mon.prototype_index][in_mon.dimension_index] = in_mon.value;
        end else begin
          if (in_mon.dimension_index < cpc_pkg::EmbedDim) begin
            longint x;
            x = longint'(in_mon.value);
            energy_acc += x * x;
            if (energy_acc > EnergyMax) energy_acc = EnergyMax;
            for (int p = 0; p < cpc_pkg::NumPrototypes; p++) begin
              dot_acc[p] += x * longint'(proto_mem[p][in_mon.dimension_index]);
              if (dot_acc[p] > AccMax) dot_acc[p] = AccMax;
              if (dot_acc[p] < AccMin) dot_acc[p] = AccMin;
            end
          end
          if (in_mon.last) begin
            verdicts_due.push_back(classify());
            for (int p = 0; p < cpc_pkg::NumPrototypes; p++) dot_acc[p] = 0;
            energy_acc = 0;
          end
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        verdict_t got, want;
        got = {out_mon.label_id, out_mon.confidence, out_mon.best_prototype, out_mon.rejected};
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected result word %p", $time, got);
          fail_count_o++;
        end else begin
          want = verdicts_due.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
            fail_count_o++;
          end
        end
      end
      pending_o = verdicts_due.size();
    end
  end
endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// Top-level testbench: drives the classifier channels and reports the verdict.
module tb;
  // Embeddings touch only the first dimensions, which are all written up front.
  localparam int UsedDims = 16;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending;

  // Idle and stall rates of the current phase, in percent.
  int   gap_pct = 0;
  int   stall_pct = 0;
  logic hold_off = 1'b0;
  int   items_sent = 0;
  int   vectors_done = 0;

  // Local copy of the prototypes, used only to shape embeddings that resemble them.
  logic signed [15:0] proto_copy [cpc_pkg::NumPrototypes][cpc_pkg::EmbedDim];

  cpc_in_if  in_ch ();
  cpc_out_if out_ch ();
  cpc_cfg_if cfg_ch ();

  cosine_prototype_classifier dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  cpc_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_mon      (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // The receiver stalls at the phase rate; a long hold-off overrides it.
  always @(posedge clk_i) begin
    out_ch.ready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin
    #5ms;
    $display("tb failed");
    $finish;
  end

  // Offers one input word after a random idle gap and waits for it to be taken.
  // Valid stays high afterwards so that back-to-back words need no extra edge.
  task automatic send_word(cpc_pkg::op_e op, logic signed [15:0] value, logic [1:0] pidx,
                           logic [9:0] didx, logic last);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid           <= 1'b1;
    in_ch.operation       <= op;
    in_ch.value           <= value;
    in_ch.prototype_index <= pidx;
    in_ch.dimension_index <= didx;
    in_ch.last            <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    if (op == cpc_pkg::OP_WRITE_PROTO && didx < cpc_pkg::EmbedDim)
      proto_copy[pidx][didx] = value;
    items_sent++;
  endtask

  // Valid drops for one cycle after each write so writes never overlap in one step.
  task automatic write_reg(cpc_pkg::reg_idx_e idx, logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Lets the block drain fully; a last word may still be in its divider.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] pick_extreme();
    case ($urandom_range(0, 3))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return -16'sd1;
      default: return 16'sd0;
    endcase
  endfunction

  // Streams one embedding. Styles: random, a scaled or negated prototype, zeros, extremes.
  // Now and then a prototype write or an out-of-range element is mixed in as noise.
  task automatic send_embedding(int len, int style);
    int start, p, shift;
    logic [9:0] didx;
    logic signed [15:0] v;
    start = $urandom_range(0, UsedDims - 1);
    p     = $urandom_range(0, cpc_pkg::NumPrototypes - 1);
    shift = $urandom_range(0, 3);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_word(cpc_pkg::OP_WRITE_PROTO, 16'($urandom), 2'($urandom), 10'($urandom),
                  1'($urandom));
      didx = ($urandom_range(0, 19) == 0) ? 10'($urandom_range(cpc_pkg::EmbedDim, 1023))
                                          : 10'((start + i) % UsedDims);
      case (style)
        0: v = 16'($urandom);
        1: v = (didx < cpc_pkg::EmbedDim) ? (proto_copy[p][didx] >>> shift)
                                          : $signed(16'($urandom));
        2: v = (didx < cpc_pkg::EmbedDim) ? -proto_copy[p][didx] : 16'sd0;
        3: v = 16'sd0;
        default: v = pick_extreme();
      endcase
      send_word(cpc_pkg::OP_EMBED, v, 2'($urandom), didx, i == len - 1);
    end
    vectors_done++;
  endtask

  task automatic random_phase(int gap, int stall, int words);
    int stop_at;
    gap_pct   = gap;
    stall_pct = stall;
    stop_at   = items_sent + words;
    while (items_sent < stop_at)
      send_embedding(($urandom_range(0, 49) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(1, 6),
                     $urandom_range(0, 4));
  endtask

  initial begin
    in_ch.valid           <= 1'b0;
    in_ch.operation       <= cpc_pkg::OP_WRITE_PROTO;
    in_ch.value           <= '0;
    in_ch.prototype_index <= '0;
    in_ch.dimension_index <= '0;
    in_ch.last            <= 1'b0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= cpc_pkg::REG_MIN_SIM;
    cfg_ch.data           <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every prototype entry that an embedding can read is written first.
    for (int p = 0; p < cpc_pkg::NumPrototypes; p++)
      for (int d = 0; d < UsedDims; d++)
        send_word(cpc_pkg::OP_WRITE_PROTO, 16'($urandom), 2'(p), 10'(d), 1'($urandom));

    // Directed words under reset-default registers.
    send_word(cpc_pkg::OP_WRITE_PROTO, -16'sd32768, 2'd0, 10'd0, 1'b1);
    send_word(cpc_pkg::OP_WRITE_PROTO, 16'sd32767, 2'd3, 10'd767, 1'b0);
    send_word(cpc_pkg::OP_WRITE_PROTO, 16'sd1234, 2'd1, 10'd1023, 1'b0);
    send_word(cpc_pkg::OP_EMBED, 16'sd5, 2'd0, 10'd900, 1'b1);
    send_embedding(1, 3);
    send_embedding(UsedDims, 1);
    send_embedding(UsedDims, 2);
    send_embedding(4, 4);
    send_embedding(3, 0);
    drain();

    // Accept everything and scramble the class ids.
    write_reg(cpc_pkg::REG_MIN_SIM, 32'h0000_8000);
    write_reg(cpc_pkg::REG_CLS_THR, 32'h0000_8000);
    write_reg(cpc_pkg::REG_CLASS_MAP, $urandom);
    send_embedding(2, 4);
    send_embedding(5, 1);
    send_embedding(3, 2);
    random_phase(0, 0, 95);

    // The receiver holds off for a long stretch while words keep coming.
    fork
      begin
        hold_off <= 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_off <= 1'b0;
      end
    join_none
    random_phase(80, 0, 95);
    drain();

    // Strictest threshold: only the maximum similarity, 32767, is accepted.
    write_reg(cpc_pkg::REG_MIN_SIM, 32'h0000_7FFF);
    write_reg(cpc_pkg::REG_CLS_THR, 32'h0000_7FFF);
    write_reg(cpc_pkg::REG_CLASS_MAP, 32'hFFFF_FFFF);
    random_phase(0, 80, 95);
    drain();

    write_reg(cpc_pkg::REG_MIN_SIM, $urandom);
    write_reg(cpc_pkg::REG_CLS_THR, $urandom_range(0, 65535) & 32'h0000_7FFF);
    write_reg(cpc_pkg::REG_CLASS_MAP, 32'h0000_0000);
    random_phase(8, 8, 95);
    drain();

    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+sv
sv/cpc_pkg.sv
sv/cpc_if.sv
sv/cosine_prototype_classifier.sv
dv/cpc_checker.sv
dv/tb.sv
